// File: sv/jsu_pkg.sv
// Package for the JSON string unescaper: item types, mode and error codes,
// UTF-8 constants and the hex digit decoder. No dependencies.
`default_nettype none
package jsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
    logic [2:0] error_code;
  } out_t;

  localparam int MaxResults = 3;

  typedef struct packed {
    logic [1:0]                  count;
    out_t [MaxResults-1:0]       res;
  } grp_t;

  localparam logic [1:0] MODE_QUOTE = 2'd0;
  localparam logic [1:0] MODE_TEXT  = 2'd1;
  localparam logic [1:0] MODE_ESC   = 2'd2;
  localparam logic [1:0] MODE_HEX   = 2'd3;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_EXP_QUOTE   = 3'd1;
  localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
  localparam logic [2:0] ERR_UNTERM_ESC  = 3'd3;
  localparam logic [2:0] ERR_BAD_UNICODE = 3'd4;
  localparam logic [2:0] ERR_UNSUP_ESC   = 3'd5;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  localparam logic [15:0] CP_ONE_MAX = 16'h007f;
  localparam logic [15:0] CP_TWO_MAX = 16'h07ff;
  localparam logic [7:0]  LEAD2      = 8'hc0;
  localparam logic [7:0]  CONT       = 8'h80;
  localparam logic [7:0]  LEAD3      = 8'he0;
  localparam logic [5:0]  CONT_MASK  = 6'h3f;

  // bit 4 set marks a non-hex byte
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/json_string_unescape_utf8.sv
// JSON string unescaper to UTF-8: top level with mode state, step logic
// and result register. Depends on jsu_pkg, jsu_decode and jsu_outbuf.
// The first result of an accepted item is registered and offered in the next cycle.
// Throughput: one item per cycle; out_ready low or multi-result items stall input.
// Reset (rst, synchronous): mode expects an opening quote, no result pending.
`default_nettype none
module json_string_unescape_utf8 (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire jsu_pkg::in_t in_item,
  output logic              out_valid,
  input  wire logic         out_ready,
  output jsu_pkg::out_t     out_item
);
  import jsu_pkg::*;

  logic [1:0]  mode, mode_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [11:0] acc, acc_next;
  grp_t        grp;
  logic        room;
  logic        take;

  assign in_ready = room;
  assign take     = in_valid && room;

  jsu_decode u_decode (
    .mode          (mode),
    .hex_seen      (hex_seen),
    .acc           (acc),
    .item          (in_item),
    .mode_next     (mode_next),
    .hex_seen_next (hex_seen_next),
    .acc_next      (acc_next),
    .grp           (grp)
  );

  jsu_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .grp       (grp),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_QUOTE;
      hex_seen <= 2'd0;
      acc      <= 12'd0;
    end else if (take) begin
      mode     <= mode_next;
      hex_seen <= hex_seen_next;
      acc      <= acc_next;
    end
  end

`ifndef SYNTHESIS
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.error_code != ERR_NONE |->
      out_item.last_of_run && !out_item.byte_valid && !out_item.string_done)
    else $error("error result not a lone final item");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  a_group_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last_of_run |-> !in_ready)
    else $error("input taken while a result group is still pending");

  a_hex_mode: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_HEX |-> hex_seen == 2'd0 && acc == 12'd0)
    else $error("hex count set outside hex mode");
`endif

endmodule
`default_nettype wire

// File: sv/jsu_decode.sv
// Step logic of the unescaper: from the mode state and one input item,
// the next state and the group of results. Depends on jsu_pkg.
`default_nettype none
module jsu_decode (
  input  wire logic [1:0]   mode,
  input  wire logic [1:0]   hex_seen,
  input  wire logic [11:0]  acc,
  input  wire jsu_pkg::in_t item,
  output logic [1:0]        mode_next,
  output logic [1:0]        hex_seen_next,
  output logic [11:0]       acc_next,
  output jsu_pkg::grp_t     grp
);
  import jsu_pkg::*;

  logic [4:0]  d;
  logic [15:0] cp;
  logic [7:0]  esc_byte;
  logic        esc_ok;

  assign d  = hex_value(item.in_byte);
  assign cp = {acc, d[3:0]};

  always_comb begin
    esc_ok = 1'b1;
    case (item.in_byte)
      CH_QUOTE: esc_byte = CH_QUOTE;
      CH_BSL:   esc_byte = CH_BSL;
      CH_SLASH: esc_byte = CH_SLASH;
      CH_B:     esc_byte = 8'h08;
      CH_F:     esc_byte = 8'h0c;
      CH_N:     esc_byte = 8'h0a;
      CH_R:     esc_byte = 8'h0d;
      CH_T:     esc_byte = 8'h09;
      default: begin
        esc_byte = 8'h00;
        esc_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next     = mode;
    hex_seen_next = hex_seen;
    acc_next      = acc;
    grp           = '0;
    unique case (mode)
      MODE_QUOTE: begin
        if (item.end_of_text || item.in_byte != CH_QUOTE) begin
          grp.count                 = 2'd1;
          grp.res[0].last_of_run    = 1'b1;
          grp.res[0].error_code     = ERR_EXP_QUOTE;
        end else begin
          mode_next = MODE_TEXT;
        end
      end
      MODE_TEXT: begin
        if (item.end_of_text) begin
          mode_next              = MODE_QUOTE;
          grp.count              = 2'd1;
          grp.res[0].last_of_run = 1'b1;
          grp.res[0].error_code  = ERR_UNTERM_STR;
        end else if (item.in_byte == CH_QUOTE) begin
          mode_next              = MODE_QUOTE;
          grp.count              = 2'd1;
          grp.res[0].last_of_run = 1'b1;
          grp.res[0].string_done = 1'b1;
        end else if (item.in_byte == CH_BSL) begin
          mode_next = MODE_ESC;
        end else begin
          grp.count              = 2'd1;
          grp.res[0].out_byte    = item.in_byte;
          grp.res[0].byte_valid  = 1'b1;
          grp.res[0].last_of_run = 1'b1;
        end
      end
      MODE_ESC: begin
        if (item.end_of_text) begin
          mode_next              = MODE_QUOTE;
          grp.count              = 2'd1;
          grp.res[0].last_of_run = 1'b1;
          grp.res[0].error_code  = ERR_UNTERM_ESC;
        end else if (item.in_byte == CH_U) begin
          mode_next     = MODE_HEX;
          hex_seen_next = 2'd0;
          acc_next      = 12'd0;
        end else if (esc_ok) begin
          mode_next              = MODE_TEXT;
          grp.count              = 2'd1;
          grp.res[0].out_byte    = esc_byte;
          grp.res[0].byte_valid  = 1'b1;
          grp.res[0].last_of_run = 1'b1;
        end else begin
          mode_next              = MODE_QUOTE;
          grp.count              = 2'd1;
          grp.res[0].last_of_run = 1'b1;
          grp.res[0].error_code  = ERR_UNSUP_ESC;
        end
      end
      MODE_HEX: begin
        if (item.end_of_text || d[4]) begin
          mode_next              = MODE_QUOTE;
          hex_seen_next          = 2'd0;
          acc_next               = 12'd0;
          grp.count              = 2'd1;
          grp.res[0].last_of_run = 1'b1;
          grp.res[0].error_code  = ERR_BAD_UNICODE;
        end else if (hex_seen != 2'd3) begin
          acc_next      = {acc[7:0], d[3:0]};
          hex_seen_next = hex_seen + 2'd1;
        end else begin
          mode_next     = MODE_TEXT;
          hex_seen_next = 2'd0;
          acc_next      = 12'd0;
          grp.res[0].byte_valid = 1'b1;
          grp.res[1].byte_valid = 1'b1;
          grp.res[2].byte_valid = 1'b1;
          if (cp <= CP_ONE_MAX) begin
            grp.count              = 2'd1;
            grp.res[0].out_byte    = cp[7:0];
            grp.res[0].last_of_run = 1'b1;
            grp.res[1].byte_valid  = 1'b0;
            grp.res[2].byte_valid  = 1'b0;
          end else if (cp <= CP_TWO_MAX) begin
            grp.count              = 2'd2;
            grp.res[0].out_byte    = LEAD2 | {3'b000, cp[10:6]};
            grp.res[1].out_byte    = CONT | {2'b00, cp[5:0] & CONT_MASK};
            grp.res[1].last_of_run = 1'b1;
            grp.res[2].byte_valid  = 1'b0;
          end else begin
            grp.count              = 2'd3;
            grp.res[0].out_byte    = LEAD3 | {4'b0000, cp[15:12]};
            grp.res[1].out_byte    = CONT | {2'b00, cp[11:6] & CONT_MASK};
            grp.res[2].out_byte    = CONT | {2'b00, cp[5:0] & CONT_MASK};
            grp.res[2].last_of_run = 1'b1;
          end
        end
      end
      default: begin
        mode_next = MODE_QUOTE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/jsu_outbuf.sv
// Result register of the unescaper: holds one group of up to three
// results and shifts them out one item at a time. Depends on jsu_pkg.
`default_nettype none
module jsu_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire jsu_pkg::grp_t grp,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jsu_pkg::out_t      out_item
);
  import jsu_pkg::*;

  out_t [MaxResults-1:0] slots;
  logic [1:0]            cnt;
  logic                  pop;

  assign out_valid = cnt != 2'd0;
  assign out_item  = slots[0];
  assign pop       = out_valid && out_ready;
  assign room      = cnt == 2'd0 || (cnt == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= grp.res;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule
`default_nettype wire

// File: tb/jsu_unescape_checker.sv
`timescale 1ns / 1ps
// Checker for the JSON string unescaper: watches both item channels, predicts
// the UTF-8 results of every accepted text byte and compares them in order.
// Depends on jsu_pkg for the item types, mode, error and character codes.
module jsu_unescape_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  jsu_pkg::in_t  in_item,
  input  logic          out_valid,
  input  logic          out_ready,
  input  jsu_pkg::out_t out_item,
  output int            fail_count,
  output int            outstanding
);
  import jsu_pkg::*;

  out_t        pending_results[$];
  out_t        oldest;
  logic [1:0]  scan_mode;
  logic [1:0]  hex_count;
  logic [11:0] code_acc;
  int          failures;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    failures    = 0;
    scan_mode   = MODE_QUOTE;
    hex_count   = 2'd0;
    code_acc    = 12'd0;
  end

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] n;
    n = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      n = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      n = 5'(c - 8'h41 + 8'd10);
    end else if (c inside {[8'h61:8'h66]}) begin
      n = 5'(c - 8'h61 + 8'd10);
    end
    return n;
  endfunction

  task automatic queue_result(input logic [7:0] b, input logic v, input logic last,
                              input logic done, input logic [2:0] err);
    out_t r;
    r.out_byte    = b;
    r.byte_valid  = v;
    r.last_of_run = last;
    r.string_done = done;
    r.error_code  = err;
    pending_results = {pending_results, r};
  endtask

  task automatic abort_string(input logic [2:0] err);
    scan_mode = MODE_QUOTE;
    hex_count = 2'd0;
    code_acc  = 12'd0;
    queue_result(8'h00, 1'b0, 1'b1, 1'b0, err);
  endtask

  task automatic encode_code_point(input logic [15:0] cp);
    if (cp <= CP_ONE_MAX) begin
      queue_result(cp[7:0], 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else if (cp <= CP_TWO_MAX) begin
      queue_result(LEAD2 | {3'b000, cp[10:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
      queue_result(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else begin
      queue_result(LEAD3 | {4'h0, cp[15:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
      queue_result(CONT | {2'b00, cp[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
      queue_result(CONT | {2'b00, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end
  endtask

  task automatic decode_text_byte(input in_t it);
    logic [7:0] c;
    logic       eot;
    logic [4:0] nib;
    c   = it.in_byte;
    eot = it.end_of_text;
    case (scan_mode)
      MODE_QUOTE: begin
        if (eot || c != CH_QUOTE) abort_string(ERR_EXP_QUOTE);
        else scan_mode = MODE_TEXT;
      end
      MODE_TEXT: begin
        if (eot) begin
          abort_string(ERR_UNTERM_STR);
        end else if (c == CH_QUOTE) begin
          scan_mode = MODE_QUOTE;
          queue_result(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
        end else if (c == CH_BSL) begin
          scan_mode = MODE_ESC;
        end else begin
          queue_result(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
        end
      end
      MODE_ESC: begin
        if (eot) begin
          abort_string(ERR_UNTERM_ESC);
        end else begin
          scan_mode = MODE_TEXT;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: queue_result(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_B: queue_result(8'h08, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_F: queue_result(8'h0c, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_N: queue_result(8'h0a, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_R: queue_result(8'h0d, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_T: queue_result(8'h09, 1'b1, 1'b1, 1'b0, ERR_NONE);
            CH_U: begin
              scan_mode = MODE_HEX;
              hex_count = 2'd0;
              code_acc  = 12'd0;
            end
            default: abort_string(ERR_UNSUP_ESC);
          endcase
        end
      end
      default: begin
        nib = hex_nibble(c);
        if (eot || nib[4]) begin
          abort_string(ERR_BAD_UNICODE);
        end else if (hex_count != 2'd3) begin
          code_acc  = {code_acc[7:0], nib[3:0]};
          hex_count = hex_count + 2'd1;
        end else begin
          scan_mode = MODE_TEXT;
          encode_code_point({code_acc, nib[3:0]});
          hex_count = 2'd0;
          code_acc  = 12'd0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_mode = MODE_QUOTE;
      hex_count = 2'd0;
      code_acc  = 12'd0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result: byte=%h valid=%b last=%b done=%b err=%0d",
                     out_item.out_byte, out_item.byte_valid, out_item.last_of_run,
                     out_item.string_done, out_item.error_code);
          end
        end else begin
          oldest = pending_results.pop_front();
          if (out_item !== oldest) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch: exp byte=%h valid=%b last=%b done=%b err=%0d,",
                       oldest.out_byte, oldest.byte_valid, oldest.last_of_run,
                       oldest.string_done, oldest.error_code,
                       " got byte=%h valid=%b last=%b done=%b err=%0d",
                       out_item.out_byte, out_item.byte_valid, out_item.last_of_run,
                       out_item.string_done, out_item.error_code);
            end
          end
        end
      end
      if (in_valid && in_ready) decode_text_byte(in_item);
    end
    fail_count  <= failures;
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/tb_json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// Top of the JSON string unescaper testbench: clock, reset, text stimulus and
// output back-pressure. Depends on jsu_pkg, the block and jsu_unescape_checker.
module tb_json_string_unescape_utf8;
  import jsu_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  int   fail_count;
  int   outstanding;

  int unsigned sent_count = 0;
  bit          calm       = 1'b0;
  bit          hold_done  = 1'b0;
  in_t         text_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_unescape_utf8 u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  jsu_unescape_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  task automatic add_byte(input logic [7:0] b);
    in_t it;
    it.in_byte     = b;
    it.end_of_text = 1'b0;
    text_q = {text_q, it};
  endtask

  task automatic add_eot();
    in_t it;
    it.in_byte     = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    text_q = {text_q, it};
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic add_unicode(input logic [15:0] cp);
    add_byte(CH_BSL);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(cp[4*i +: 4], 1'($urandom_range(0, 1))));
  endtask

  function automatic logic [7:0] escape_letter(input int idx);
    case (idx)
      0: return CH_QUOTE;
      1: return CH_BSL;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(16'h0000, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hffff));
      3: return 16'($urandom_range(16'hd800, 16'hdfff));
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h007f;
          2: return 16'h0080;
          3: return 16'h07ff;
          4: return 16'h0800;
          default: return 16'hffff;
        endcase
      end
    endcase
  endfunction

  task automatic build_string();
    logic [7:0] b;
    int         pieces;
    pieces = $urandom_range(0, 8);
    add_byte(CH_QUOTE);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSL);
          add_byte(b);
        end
        4, 5, 6: begin
          add_byte(CH_BSL);
          add_byte(escape_letter($urandom_range(0, 7)));
        end
        default: add_unicode(pick_code_point());
      endcase
    end
    add_byte(CH_QUOTE);
  endtask

  task automatic build_random_text();
    int   cut;
    int   pos;
    in_t  junk;
    case ($urandom_range(0, 9))
      7: begin
        build_string();
        cut = $urandom_range(1, text_q.size() - 1);
        while (text_q.size() > cut) void'(text_q.pop_back());
        add_eot();
      end
      8: begin
        build_string();
        pos = $urandom_range(1, text_q.size() - 1);
        junk.in_byte     = 8'($urandom_range(0, 255));
        junk.end_of_text = ($urandom_range(0, 3) == 0);
        text_q[pos]      = junk;
      end
      9: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 7) == 0) add_eot();
          else add_byte(8'($urandom_range(0, 255)));
        end
      end
      default: build_string();
    endcase
  endtask

  task automatic offer_item(input in_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    if (sent_count >= 370) calm = 1'b1;
  endtask

  task automatic send_text();
    while (text_q.size() != 0) offer_item(text_q.pop_front());
  endtask

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else if (!hold_done && sent_count >= 120) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_eot();
    add_byte(CH_QUOTE);
    add_byte(8'hff);
    add_byte(CH_BSL);
    add_byte(CH_N);
    add_byte(CH_BSL);
    add_byte(CH_U);
    add_byte(8'h46);
    add_byte(8'h66);
    add_byte(8'h46);
    add_byte(8'h66);
    add_byte(CH_QUOTE);
    add_byte(CH_QUOTE);
    add_eot();
    add_byte(CH_QUOTE);
    add_byte(CH_BSL);
    add_eot();
    add_byte(CH_QUOTE);
    add_byte(CH_BSL);
    add_byte(8'h71);
    add_byte(CH_QUOTE);
    add_byte(CH_BSL);
    add_byte(CH_U);
    add_byte(8'h30);
    add_byte(8'h67);
    send_text();

    while (sent_count < 400) begin
      build_random_text();
      send_text();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[json_string_unescape_utf8] OK");
    end else begin
      $display("[json_string_unescape_utf8] ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[json_string_unescape_utf8] ERROR");
    $finish;
  end

endmodule

// File: json_string_unescape_utf8.f
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_outbuf.sv
sv/json_string_unescape_utf8.sv
tb/jsu_unescape_checker.sv
tb/tb_json_string_unescape_utf8.sv
